// ===== rtl/tsp_pkg.sv =====
package tsp_pkg;

    // Default number of table entries.
    localparam int TSP_TABLE_DEPTH = 64;

    // Tick period and the silent gap after the last entry, in milliseconds.
    localparam logic [15:0] TSP_STEP_MS = 16'd10;
    localparam logic [15:0] TSP_GAP_MS  = 16'd250;

    // One table entry holds the tone in the upper half and the duration in the lower half.
    localparam int TSP_ENTRY_W = 32;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_WRITE = 2'd3
    } t_tsp_func;

    typedef struct packed {
        t_tsp_func   func;
        logic [5:0]  entry_index;
        logic [15:0] entry_tone;
        logic [15:0] entry_length;
        logic [6:0]  start_length;
        logic [7:0]  start_volume;
        logic        start_loop;
    } t_tsp_item;

    typedef struct packed {
        logic        active;
        logic        tone_update;
        logic [15:0] tone_freq;
        logic [7:0]  volume;
        logic        mute;
    } t_tsp_result;

endpackage

// ===== rtl/tsp_if.sv =====
// Request channel into the player.
interface tsp_req_if
    import tsp_pkg::*;
();
    logic        valid;
    logic        ready;
    t_tsp_func   func;
    logic [5:0]  entry_index;
    logic [15:0] entry_tone;
    logic [15:0] entry_length;
    logic [6:0]  start_length;
    logic [7:0]  start_volume;
    logic        start_loop;

    modport source (
        output valid, func, entry_index, entry_tone, entry_length,
               start_length, start_volume, start_loop,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, entry_tone, entry_length,
               start_length, start_volume, start_loop,
        output ready
    );
endinterface

// Result channel out of the player.
interface tsp_rsp_if;
    logic        valid;
    logic        ready;
    logic        active;
    logic        tone_update;
    logic [15:0] tone_freq;
    logic [7:0]  volume;
    logic        mute;

    modport source (
        output valid, active, tone_update, tone_freq, volume, mute,
        input  ready
    );
    modport sink (
        input  valid, active, tone_update, tone_freq, volume, mute,
        output ready
    );
endinterface

// ===== rtl/tone_sequence_player.sv =====
// Tone sequence player.
// Requests arrive on i_req: tick (one 10 ms step), start (length, volume, loop),
// stop, and table write (tone and duration into one slot, taken only while idle).
// Every request produces exactly one result on o_rsp: whether a sequence is active,
// a tone update with frequency and volume, and a mute flag.
// The result is held in the output register from the cycle after the request is
// accepted. Throughput is one request per cycle while the receiver keeps taking
// results; the table entry for the next tick is prefetched from the entry RAM,
// which keeps up that rate (one read port, read issued for the next play index).
// A request is accepted while the output register is empty or being emptied in the
// same cycle; when the receiver stalls, the result is held and i_req.ready drops.
// Reset idles the sequencer and empties the output register; the table contents
// are undefined until written.
module tone_sequence_player
    import tsp_pkg::*;
#(
    parameter int TABLE_DEPTH = TSP_TABLE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tsp_req_if.sink   i_req,
    tsp_rsp_if.source o_rsp
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                   accept;
    t_tsp_item              item;
    t_tsp_result            result;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [TSP_ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [TSP_ENTRY_W-1:0] ram_rdata;

    logic        r_out_valid, n_out_valid;
    t_tsp_result r_out;

    // Request handshake.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign item.func         = i_req.func;
    assign item.entry_index  = i_req.entry_index;
    assign item.entry_tone   = i_req.entry_tone;
    assign item.entry_length = i_req.entry_length;
    assign item.start_length = i_req.start_length;
    assign item.start_volume = i_req.start_volume;
    assign item.start_loop   = i_req.start_loop;

    tsp_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .o_result    (result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    tsp_ram #(
        .WIDTH (TSP_ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.active      = r_out.active;
    assign o_rsp.tone_update = r_out.tone_update;
    assign o_rsp.tone_freq   = r_out.tone_freq;
    assign o_rsp.volume      = r_out.volume;
    assign o_rsp.mute        = r_out.mute;

endmodule

// ===== rtl/tsp_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module tsp_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address collision.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tsp_core.sv =====
// Sequencer state and update logic. The table read for the current play index is
// issued early, using the next play index as the read address, so the
// entry is ready whenever the following tick arrives.
module tsp_core
    import tsp_pkg::*;
#(
    parameter  int TABLE_DEPTH = TSP_TABLE_DEPTH,
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 2)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_tsp_item              i_item,
    output t_tsp_result            o_result,
    output logic                   o_ram_we,
    output logic [ADDR_W-1:0]      o_ram_waddr,
    output logic [TSP_ENTRY_W-1:0] o_ram_wdata,
    output logic [ADDR_W-1:0]      o_ram_raddr,
    input  logic [TSP_ENTRY_W-1:0] i_ram_rdata
);

    logic             r_enabled, n_enabled;
    logic [CNT_W-1:0] r_play_index, n_play_index;
    logic [15:0]      r_remaining_ms, n_remaining_ms;
    logic [CNT_W-1:0] r_seq_count, n_seq_count;
    logic [7:0]       r_held_volume, n_held_volume;
    logic             r_loop_on, n_loop_on;

    logic                   r_fwd_hit, n_fwd_hit;
    logic [TSP_ENTRY_W-1:0] r_fwd_data;
    logic [TSP_ENTRY_W-1:0] entry;
    logic                   slot_ok;
    logic                   len_sat;

    // A write that hit the entry being prefetched wins over the stale read data.
    assign entry = r_fwd_hit ? r_fwd_data : i_ram_rdata;

    assign slot_ok = {2'b00, i_item.entry_index} < 8'(TABLE_DEPTH);
    assign len_sat = {1'b0, i_item.start_length} > 8'(TABLE_DEPTH);

    // Next-state and result logic for one request.
    always_comb begin
        n_enabled      = r_enabled;
        n_play_index   = r_play_index;
        n_remaining_ms = r_remaining_ms;
        n_seq_count    = r_seq_count;
        n_held_volume  = r_held_volume;
        n_loop_on      = r_loop_on;
        o_result       = '0;
        o_ram_we       = 1'b0;

        if (i_accept) begin
            case (i_item.func)
                FUNC_TICK: begin
                    if (r_enabled) begin
                        if (r_remaining_ms > TSP_STEP_MS) begin
                            n_remaining_ms = r_remaining_ms - TSP_STEP_MS;
                        end else if (r_play_index == r_seq_count + CNT_W'(1)) begin
                            if (r_loop_on) begin
                                n_play_index   = '0;
                                n_remaining_ms = '0;
                            end else begin
                                n_enabled     = 1'b0;
                                o_result.mute = 1'b1;
                            end
                        end else begin
                            if (r_play_index < r_seq_count) begin
                                o_result.tone_freq = entry[31:16];
                                n_remaining_ms     = entry[15:0];
                            end else begin
                                o_result.tone_freq = '0;
                                n_remaining_ms     = TSP_GAP_MS;
                            end
                            n_play_index         = r_play_index + CNT_W'(1);
                            o_result.volume      = r_held_volume;
                            o_result.tone_update = 1'b1;
                        end
                    end
                end
                FUNC_START: begin
                    n_enabled      = 1'b1;
                    n_seq_count    = len_sat ? CNT_W'(TABLE_DEPTH)
                                             : CNT_W'(i_item.start_length);
                    n_play_index   = '0;
                    n_remaining_ms = '0;
                    n_held_volume  = i_item.start_volume;
                    n_loop_on      = i_item.start_loop;
                    o_result.mute  = 1'b1;
                end
                FUNC_STOP: begin
                    n_enabled     = 1'b0;
                    o_result.mute = 1'b1;
                end
                FUNC_WRITE: begin
                    o_ram_we = !r_enabled && slot_ok;
                end
                default: begin
                    o_ram_we = 1'b0;
                end
            endcase
        end

        o_result.active = n_enabled;
    end

    assign o_ram_waddr = ADDR_W'(i_item.entry_index);
    assign o_ram_wdata = {i_item.entry_tone, i_item.entry_length};
    assign o_ram_raddr = n_play_index[ADDR_W-1:0];
    assign n_fwd_hit   = o_ram_we && (o_ram_waddr == o_ram_raddr);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_play_index   <= '0;
            r_remaining_ms <= '0;
            r_seq_count    <= '0;
            r_held_volume  <= '0;
            r_loop_on      <= 1'b0;
            r_fwd_hit      <= 1'b0;
        end else begin
            r_enabled      <= n_enabled;
            r_play_index   <= n_play_index;
            r_remaining_ms <= n_remaining_ms;
            r_seq_count    <= n_seq_count;
            r_held_volume  <= n_held_volume;
            r_loop_on      <= n_loop_on;
            r_fwd_hit      <= n_fwd_hit;
        end
    end

    // Forwarded write data.
    always_ff @(posedge i_clk) begin
        r_fwd_data <= o_ram_wdata;
    end

    // The play index never runs more than one slot past the gap slot of the sequence.
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enabled |-> (r_play_index <= r_seq_count + CNT_W'(1)))
        else $error("play index beyond end of sequence");

    // The sequence length is never longer than the table.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_count <= CNT_W'(TABLE_DEPTH))
        else $error("sequence length exceeds table depth");

    // The table is never written while a sequence plays.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> !r_enabled)
        else $error("table written during playback");

    // A start request rewinds the sequence.
    a_start_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.func == FUNC_START) |=>
            (r_enabled && r_play_index == '0 && r_remaining_ms == '0))
        else $error("start did not rewind the sequence");

endmodule
